// ----- rtl/core/suk_pkg.sv -----
// Shared types for the sorted unique key table.
package suk_pkg;

  localparam int unsigned KeyInW = 32;
  localparam int unsigned PosW   = 9;

  typedef struct packed {
    logic              kind;
    logic [KeyInW-1:0] key;
  } suk_in_t;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] position;
    logic            inserted;
    logic            full_res;
  } suk_out_t;

  localparam logic KindLookup = 1'b0;
  localparam logic KindInsert = 1'b1;

  typedef struct packed {
    logic load;
    logic read_mid;
    logic set_hit;
    logic narrow;
    logic set_full;
    logic shift_init;
    logic shift_step;
    logic write_key;
    logic finish;
  } suk_cmd_t;

  typedef struct packed {
    logic range_open;
    logic equal;
    logic is_insert;
    logic is_full;
    logic shift_more;
    logic wr_pend;
  } suk_status_t;

endpackage

// ----- rtl/core/suk_ctrl.sv -----
// Controller state machine for the sorted unique key table.
module suk_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  suk_pkg::suk_status_t status_i,
  output suk_pkg::suk_cmd_t   cmd_o
);
  import suk_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_READ   = 7'b0000010,
    ST_CMP    = 7'b0000100,
    ST_SHIFT  = 7'b0001000,
    ST_WRITE  = 7'b0010000,
    ST_FINISH = 7'b0100000,
    ST_SPARE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        if (status_i.range_open) begin
          cmd_o.read_mid = 1'b1;
          state_d        = ST_CMP;
        end else if (!status_i.is_insert) begin
          state_d = ST_FINISH;
        end else if (status_i.is_full) begin
          cmd_o.set_full = 1'b1;
          state_d        = ST_FINISH;
        end else begin
          cmd_o.shift_init = 1'b1;
          state_d          = ST_SHIFT;
        end
      end
      ST_CMP: begin
        if (status_i.equal) begin
          cmd_o.set_hit = 1'b1;
          state_d       = ST_FINISH;
        end else begin
          cmd_o.narrow = 1'b1;
          state_d      = ST_READ;
        end
      end
      ST_SHIFT: begin
        if (status_i.shift_more) begin
          cmd_o.shift_step = 1'b1;
        end else if (!status_i.wr_pend) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.write_key = 1'b1;
        state_d         = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/suk_datapath.sv -----
// Datapath of the sorted unique key table: key memory, search bounds, shifter, result.
module suk_datapath #(
  parameter int unsigned CAPACITY  = 256,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  suk_pkg::suk_in_t     in_data_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_data_i,
  input  suk_pkg::suk_cmd_t    cmd_i,
  output suk_pkg::suk_status_t status_o,
  output suk_pkg::suk_out_t    out_data_o
);
  import suk_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [KEY_WIDTH-1:0] mem [CAPACITY];

  logic                 cmp_signed_q;
  logic [CW-1:0]        count_q;
  logic                 kind_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [CW-1:0]        lo_q, hi_q, mid_q, ptr_q;
  logic [AW-1:0]        wr_ptr_q;
  logic                 wr_pend_q;
  logic [KEY_WIDTH-1:0] rd_q;
  logic                 hit_q, ins_q, full_q;
  suk_out_t             out_q;

  logic [CW-1:0]        mid;
  logic [CW-1:0]        ptr_m1;
  logic [KEY_WIDTH-1:0] flip, needle, probe;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [KEY_WIDTH-1:0] mem_wdata;

  assign mid    = lo_q + ((hi_q - lo_q) >> 1);
  assign ptr_m1 = ptr_q - CW'(1);
  assign flip   = KEY_WIDTH'(cmp_signed_q) << (KEY_WIDTH - 1);
  assign needle = key_q ^ flip;
  assign probe  = rd_q ^ flip;

  assign status_o.range_open = lo_q < hi_q;
  assign status_o.equal      = needle == probe;
  assign status_o.is_insert  = kind_q == KindInsert;
  assign status_o.is_full    = count_q == CW'(CAPACITY);
  assign status_o.shift_more = ptr_q > lo_q;
  assign status_o.wr_pend    = wr_pend_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_ptr_q;
    mem_wdata = rd_q;
    if (wr_pend_q) begin
      mem_we = 1'b1;
    end else if (cmd_i.write_key) begin
      mem_we    = 1'b1;
      mem_waddr = lo_q[AW-1:0];
      mem_wdata = key_q;
    end
    mem_re    = cmd_i.read_mid | cmd_i.shift_step;
    mem_raddr = cmd_i.read_mid ? mid[AW-1:0] : ptr_m1[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_signed_q <= 1'b0;
      count_q      <= '0;
      wr_pend_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cmp_signed_q <= cfg_data_i;
      end
      if (cmd_i.write_key) begin
        count_q <= count_q + CW'(1);
      end
      wr_pend_q <= cmd_i.shift_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_data_i.kind;
      key_q  <= KEY_WIDTH'(in_data_i.key);
      lo_q   <= '0;
      hi_q   <= count_q;
      hit_q  <= 1'b0;
      ins_q  <= 1'b0;
      full_q <= 1'b0;
    end
    if (cmd_i.read_mid) begin
      mid_q <= mid;
    end
    if (cmd_i.set_hit) begin
      hit_q <= 1'b1;
      lo_q  <= mid_q;
    end
    if (cmd_i.narrow) begin
      if (needle > probe) begin
        lo_q <= mid_q + CW'(1);
      end else begin
        hi_q <= mid_q;
      end
    end
    if (cmd_i.set_full) begin
      full_q <= 1'b1;
    end
    if (cmd_i.shift_init) begin
      ptr_q <= count_q;
    end
    if (cmd_i.shift_step) begin
      ptr_q    <= ptr_m1;
      wr_ptr_q <= ptr_q[AW-1:0];
    end
    if (cmd_i.write_key) begin
      ins_q <= 1'b1;
    end
    if (cmd_i.finish) begin
      out_q.found    <= hit_q;
      out_q.position <= (hit_q || ins_q) ? PosW'(lo_q) : '0;
      out_q.inserted <= ins_q;
      out_q.full_res <= full_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- rtl/core/sorted_unique_key_table.sv -----
// Top level of the sorted unique key table.
// Keeps up to CAPACITY distinct keys in ascending order in a key memory with one read and
// one write port and answers lookup and insert-if-absent items with one result each. A
// binary search step is a memory read followed by a compare of the read key. An insert of
// a new key then shifts every larger key up one slot, one entry per cycle through the
// memory ports, then drains the last pending write and stores the key. One item is worked
// on at a time; the next is accepted while the previous result waits in the output
// register. compare_signed picks unsigned or two's complement key order; the user must
// write it through the cfg channel only while the block is idle, which the block itself
// does not enforce; changing it does not re-sort stored keys.
module sorted_unique_key_table #(
  parameter int unsigned CAPACITY  = 256,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  suk_pkg::suk_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output suk_pkg::suk_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i
);
  import suk_pkg::*;

  suk_cmd_t    cmd;
  suk_status_t status;

  assign cfg_ready_o = 1'b1;

  suk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  suk_datapath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

// ----- rtl/core/suk_checker.sv -----
// Port-level checker for the sorted unique key table, with its bind.
module suk_assertions (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input suk_pkg::suk_out_t out_data_o
);
  import suk_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({out_data_o.found, out_data_o.inserted,
                                out_data_o.full_res}) <= 1)
    else $error("result flags not exclusive");

  a_position_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found && !out_data_o.inserted |->
      out_data_o.position == '0)
    else $error("position set without match or insert");

endmodule

bind sorted_unique_key_table suk_assertions u_suk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
